// ===== sv/bvd_pkg.sv =====
// Shared types, codes, constants and lookup functions of the BCD value decoder.
`default_nettype none

package bvd_pkg;

    // Value kinds
    localparam logic [1:0] KIND_NUMBER = 2'd0;
    localparam logic [1:0] KIND_DATE   = 2'd1;
    localparam logic [1:0] KIND_TIME   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_VALUE_KIND  = 2'd0;
    localparam logic [1:0] REG_DIGIT_LIMIT = 2'd1;
    localparam logic [1:0] REG_LENGTH_MASK = 2'd2;

    // Reset values of the configuration registers
    localparam logic [1:0] VALUE_KIND_RST  = KIND_NUMBER;
    localparam logic [4:0] DIGIT_LIMIT_RST = 5'd12;
    localparam logic [7:0] LENGTH_MASK_RST = 8'd32;

    // Limits
    localparam logic [3:0]  MAX_BYTES      = 4'd8;
    localparam logic [3:0]  COUNT_SAT      = 4'd9;
    localparam logic [4:0]  MAX_BCD_DIGITS = 5'd18;
    localparam logic [3:0]  MAX_NIBBLE     = 4'd9;
    localparam logic [6:0]  MAX_HOUR       = 7'd23;
    localparam logic [6:0]  MAX_MINUTE     = 7'd59;
    localparam logic [6:0]  MONTHS         = 7'd12;
    localparam logic [6:0]  FEBRUARY       = 7'd2;
    localparam logic [63:0] DATE_TIME_MAX  = 64'd999999;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic        status;
        logic [63:0] value;
        logic [6:0]  field_high;
        logic [6:0]  field_mid;
        logic [6:0]  field_low;
    } out_t;

    typedef struct packed {
        logic [1:0] value_kind;
        logic [4:0] digit_limit;
        logic [7:0] allowed_length_mask;
    } cfg_t;

    // Snapshot of one finished value, handed from accumulator to checker
    typedef struct packed {
        logic [63:0] acc;
        logic [3:0]  count;
        logic        bad;
        logic [6:0]  pair_high;
        logic [6:0]  pair_mid;
        logic [6:0]  pair_low;
    } snap_t;

    // Largest number with the given count of decimal digits
    function automatic logic [63:0] digit_max(input logic [4:0] digits);
        logic [63:0] res;
        res = 64'd0;
        case (digits)
            5'd0:    res = 64'd0;
            5'd1:    res = 64'd9;
            5'd2:    res = 64'd99;
            5'd3:    res = 64'd999;
            5'd4:    res = 64'd9999;
            5'd5:    res = 64'd99999;
            5'd6:    res = 64'd999999;
            5'd7:    res = 64'd9999999;
            5'd8:    res = 64'd99999999;
            5'd9:    res = 64'd999999999;
            5'd10:   res = 64'd9999999999;
            5'd11:   res = 64'd99999999999;
            5'd12:   res = 64'd999999999999;
            5'd13:   res = 64'd9999999999999;
            5'd14:   res = 64'd99999999999999;
            5'd15:   res = 64'd999999999999999;
            5'd16:   res = 64'd9999999999999999;
            5'd17:   res = 64'd99999999999999999;
            default: res = 64'd999999999999999999;
        endcase
        return res;
    endfunction

    // Days in a month of a common year, month counted from one
    function automatic logic [4:0] month_days(input logic [6:0] month);
        logic [4:0] res;
        res = 5'd31;
        case (month) inside
            7'd2:                      res = 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11:   res = 5'd30;
            default:                   res = 5'd31;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/bvd_accum.sv =====
// Byte accumulator: folds request bytes into the running value and hands off finished values.
`default_nettype none

module bvd_accum
    import bvd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire in_t   in_data,
    input  wire logic  chk_ready,
    output logic       snap_valid,
    output snap_t      snap
);

    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [3:0]  count_reg;
    logic [3:0]  count_next;
    logic        bad_reg;
    logic        bad_next;
    logic [6:0]  pair_mid_reg;
    logic [6:0]  pair_low_reg;
    logic        fin_valid_reg;
    snap_t       fin_reg;
    snap_t       fin_next;
    logic        in_fire;
    logic        binary;
    logic [3:0]  hi;
    logic [3:0]  lo;
    logic [7:0]  pair;
    logic [63:0] acc_bcd;

    // Stall while a finished value waits and the checker cannot take it
    assign in_stall = fin_valid_reg && !chk_ready;
    assign in_fire  = in_valid && !in_stall;

    // Decode the incoming byte
    assign binary = (cfg.value_kind == KIND_NUMBER) && (cfg.digit_limit == 5'd0);
    assign hi     = in_data.data_byte[7:4];
    assign lo     = in_data.data_byte[3:0];
    assign pair   = {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'b0000, lo};

    // Multiply by one hundred as shifted adds, then add the digit pair
    assign acc_bcd = {acc_reg[57:0], 6'b0} + {acc_reg[58:0], 5'b0}
                   + {acc_reg[61:0], 2'b0} + {56'd0, pair};

    assign acc_next   = binary ? {acc_reg[55:0], in_data.data_byte} : acc_bcd;
    assign bad_next   = bad_reg || (!binary && ((hi > MAX_NIBBLE) || (lo > MAX_NIBBLE)));
    assign count_next = (count_reg == COUNT_SAT) ? COUNT_SAT : count_reg + 4'd1;

    // The oldest of the three pairs is only needed once it has shifted out
    always_comb
    begin
        fin_next.acc       = acc_next;
        fin_next.count     = count_next;
        fin_next.bad       = bad_next;
        fin_next.pair_high = pair_mid_reg;
        fin_next.pair_mid  = pair_low_reg;
        fin_next.pair_low  = pair[6:0];
    end

    // Advance the working state; clear it after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 64'd0;
            count_reg     <= 4'd0;
            bad_reg       <= 1'b0;
            pair_mid_reg  <= 7'd0;
            pair_low_reg  <= 7'd0;
        end
        else if (in_fire)
        begin
            if (in_data.last_byte)
            begin
                acc_reg       <= 64'd0;
                count_reg     <= 4'd0;
                bad_reg       <= 1'b0;
                pair_mid_reg  <= 7'd0;
                pair_low_reg  <= 7'd0;
            end
            else
            begin
                acc_reg       <= acc_next;
                count_reg     <= count_next;
                bad_reg       <= bad_next;
                pair_mid_reg  <= pair_low_reg;
                pair_low_reg  <= pair[6:0];
            end
        end
    end

    // Hold the finished value until the checker takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (in_fire && in_data.last_byte)
        begin
            fin_valid_reg <= 1'b1;
        end
        else if (chk_ready)
        begin
            fin_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && in_data.last_byte)
        begin
            fin_reg <= fin_next;
        end
    end

    assign snap_valid = fin_valid_reg;
    assign snap       = fin_reg;

    // Byte count never passes its saturation point
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_SAT)
        else $error("byte count above saturation");

    // A handed-off value always holds at least one byte
    a_fin_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid_reg |-> (fin_reg.count != 4'd0))
        else $error("finished value with no bytes");

    // The last byte clears the working state
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.last_byte) |=> (count_reg == 4'd0 && !bad_reg))
        else $error("working state not cleared after last byte");

endmodule

`default_nettype wire

// ===== sv/bvd_check.sv =====
// Value checker: validates a finished value and holds the result in the output register.
`default_nettype none

module bvd_check
    import bvd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  snap_valid,
    input  wire snap_t snap,
    output logic       chk_ready,
    output logic       out_valid,
    input  wire logic  out_stall,
    output out_t       out_data
);

    logic       out_valid_reg;
    out_t       out_data_reg;
    out_t       out_data_next;
    logic       ok;
    logic       len_ok;
    logic [2:0] len_idx;
    logic [4:0] day_lim;
    logic       leap_feb;

    // Take a new value when the output register is free or being drained
    assign chk_ready = !out_valid_reg || !out_stall;

    assign len_idx  = 3'(snap.count - 4'd1);
    assign len_ok   = (snap.count <= MAX_BYTES) && cfg.allowed_length_mask[len_idx];
    assign leap_feb = (snap.pair_mid == FEBRUARY) && (snap.pair_high[1:0] == 2'b00);
    assign day_lim  = month_days(snap.pair_mid) + {4'd0, leap_feb};

    // Check length, digits, range and fields
    always_comb
    begin
        ok = len_ok;
        unique case (cfg.value_kind)
            KIND_NUMBER:
            begin
                if (cfg.digit_limit > MAX_BCD_DIGITS)
                begin
                    ok = 1'b0;
                end
                else if (cfg.digit_limit != 5'd0)
                begin
                    if (snap.bad || (snap.acc > digit_max(cfg.digit_limit)))
                    begin
                        ok = 1'b0;
                    end
                end
            end
            KIND_DATE:
            begin
                if (snap.bad || (snap.acc > DATE_TIME_MAX))
                begin
                    ok = 1'b0;
                end
                else if ((snap.pair_mid == 7'd0) || (snap.pair_mid > MONTHS))
                begin
                    ok = 1'b0;
                end
                else if ((snap.pair_low == 7'd0) || (snap.pair_low > {2'b00, day_lim}))
                begin
                    ok = 1'b0;
                end
            end
            KIND_TIME:
            begin
                if (snap.bad || (snap.acc > DATE_TIME_MAX))
                begin
                    ok = 1'b0;
                end
                else if ((snap.pair_high > MAX_HOUR) || (snap.pair_mid > MAX_MINUTE)
                         || (snap.pair_low > MAX_MINUTE))
                begin
                    ok = 1'b0;
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // Build the result; zero the payload when invalid
    always_comb
    begin
        out_data_next.status     = !ok;
        out_data_next.value      = ok ? snap.acc : 64'd0;
        out_data_next.field_high = 7'd0;
        out_data_next.field_mid  = 7'd0;
        out_data_next.field_low  = 7'd0;
        if (ok && ((cfg.value_kind == KIND_DATE) || (cfg.value_kind == KIND_TIME)))
        begin
            out_data_next.field_high = snap.pair_high;
            out_data_next.field_mid  = snap.pair_mid;
            out_data_next.field_low  = snap.pair_low;
        end
    end

    // Load or drain the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (chk_ready)
        begin
            out_valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chk_ready && snap_valid)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // An invalid result carries an all-zero payload
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status) |->
            (out_data_reg.value == 64'd0 && out_data_reg.field_high == 7'd0
             && out_data_reg.field_mid == 7'd0 && out_data_reg.field_low == 7'd0))
        else $error("invalid result with nonzero payload");

endmodule

`default_nettype wire

// ===== sv/bcd_value_decoder_core.sv =====
// Top level of the BCD value decoder: configuration registers and the two processing stages.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one byte per request,
//   most significant first, with last_byte set on the final byte of a value.
//   Output channel (out_valid / out_stall / out_data) carries one result per
//   value: status, decoded number and, in date or time mode, the three fields.
//   Configuration (cfg_write / cfg_index / cfg_data) writes value_kind (0),
//   digit_limit (1) and allowed_length_mask (2); other indexes are ignored.
//   Throughput: one byte per cycle while in_stall is low, set by the single
//   multiply-by-100 accumulate in the byte accumulator. Once its last byte is
//   accepted, the result of a value passes through the finished-value
//   register, then the output register.
//   Reset clears the working value, empties both stages and loads the
//   register defaults: kind number, digit limit 12, length mask 0x20.
//   While the receiver stalls, the output holds its result, the finished
//   value waits one stage behind it, and only then is in_stall raised.
`default_nettype none

module bcd_value_decoder_core
    import bvd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire in_t        in_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_t            out_data
);

    cfg_t  cfg_reg;
    logic  snap_valid;
    snap_t snap;
    logic  chk_ready;

    // Decode configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.value_kind          <= VALUE_KIND_RST;
            cfg_reg.digit_limit         <= DIGIT_LIMIT_RST;
            cfg_reg.allowed_length_mask <= LENGTH_MASK_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_VALUE_KIND:  cfg_reg.value_kind          <= cfg_data[1:0];
                REG_DIGIT_LIMIT: cfg_reg.digit_limit         <= cfg_data[4:0];
                REG_LENGTH_MASK: cfg_reg.allowed_length_mask <= cfg_data;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    bvd_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .chk_ready  (chk_ready),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    bvd_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .snap_valid (snap_valid),
        .snap       (snap),
        .chk_ready  (chk_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire
